>>> design/iirdf1_pkg.sv
// Shared types, widths and register indexes for the direct form I filter.
package iirdf1_pkg;

   // Field and coefficient widths.
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int QUOT_W     = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;

   // Tap counts and the widths that follow from them.
   localparam int NTAPS_MAX     = 4;
   localparam int NTAPS_DEFAULT = 4;
   localparam int COEF_IDX_W    = $clog2(NTAPS_MAX);
   localparam int ACC_W_DEFAULT = PROD_W + $clog2(2 * NTAPS_DEFAULT);

   // Configuration register indexes.
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DEN_COEF_0 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DEN_COEF_1 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DEN_COEF_2 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_DEN_COEF_3 = 3'd7;

   // Coefficient reset values: unity in Q4.12, and zero.
   localparam logic signed [COEF_W-1:0] COEF_UNITY = 16'sd4096;
   localparam logic signed [COEF_W-1:0] COEF_ZERO  = 16'sd0;

   // Output clipping limits and the largest magnitude a negative result may have.
   localparam logic signed [SAMPLE_W-1:0] Y_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] Y_MIN = -16'sd32768;
   localparam logic [QUOT_W-1:0] NEG_LIMIT_MAG  = 16'h8000;

   // Sequencer states of the filter core.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Status returned by the serial divider.
   typedef struct packed {
      logic done;
      logic overflow;
   } div_status_type;

endpackage

>>> design/iirdf1_div.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module iirdf1_div #(
   parameter int DIVIDEND_W = iirdf1_pkg::ACC_W_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             div_start,
   input  logic [DIVIDEND_W-1:0]            dividend,
   input  logic [iirdf1_pkg::COEF_W-1:0]    divisor,
   output logic [iirdf1_pkg::QUOT_W-1:0]    quotient,
   output iirdf1_pkg::div_status_type       status
);
   import iirdf1_pkg::*;

   localparam int REM_W = COEF_W + QUOT_W - 1;
   localparam int CNT_W = $clog2(QUOT_W);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsh_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              big_ff;
   logic [REM_W:0]    diff;
   logic              bit_in;

   // Trial subtraction of the shifted divisor from the partial remainder.
   always_comb begin
      diff   = {1'b0, rem_ff} - {1'b0, dsh_ff};
      bit_in = ~diff[REM_W];
      rem_in = bit_in ? diff[REM_W-1:0] : rem_ff;
   end

   // Control: a start loads the operands, then sixteen steps follow.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff & ~div_start & (cnt_ff == CNT_W'(QUOT_W - 1));
         if (div_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: remainder, shifting divisor and quotient shift register.
   always_ff @(posedge clock) begin
      if (div_start) begin
         // A quotient of 2^16 or more cannot be represented and clips anyway.
         big_ff  <= dividend >= DIVIDEND_W'({divisor, QUOT_W'(0)});
         rem_ff  <= dividend[REM_W-1:0];
         dsh_ff  <= {divisor, (QUOT_W - 1)'(0)};
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[QUOT_W-2:0], bit_in};
      end
   end

   assign quotient        = quot_ff;
   assign status.done     = done_ff;
   assign status.overflow = big_ff;

endmodule

>>> design/iir_direct_form_one.sv
// Top level of the direct form I IIR filter with serial division.
//
// Requests arrive on req_valid / req_stall with one Q1.15 sample in req_x_sample.
// Each request yields one response on rsp_valid / rsp_stall carrying the
// saturated Q1.15 output, a saturation flag and a divide fault flag.
// Coefficients are written through csr_wr_en, csr_index and csr_wr_data; the user
// must write them only while the filter is idle; the block itself does not
// enforce this. Indexes 0 to 3 are numerator taps, 4 to 7 denominator taps.
// A taken request passes through multiply-accumulate (two 16 by 16 multipliers,
// one tap per cycle), drain, load, the bit-serial divider, one quotient bit per
// cycle, and finish. One request is in flight at a time, so a new request is not
// taken until the previous one has finished. The result sits in an output
// register; the next request is taken while it waits, but that request cannot
// finish until the receiver takes the previous response. Synchronous reset
// clears both histories, sets the coefficients to unity over unity and empties
// the output register.
module iir_direct_form_one #(
   parameter int NTAPS = iirdf1_pkg::NTAPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] req_x_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [iirdf1_pkg::SAMPLE_W-1:0] rsp_y_sample,
   output logic                                   rsp_saturated,
   output logic                                   rsp_divide_fault,
   input  logic                                   csr_wr_en,
   input  logic [iirdf1_pkg::REG_IDX_W-1:0]       csr_index,
   input  logic [iirdf1_pkg::COEF_W-1:0]          csr_wr_data
);
   import iirdf1_pkg::*;

   localparam int IDX_W = (NTAPS > 1) ? $clog2(NTAPS) : 1;
   localparam int ACC_W = PROD_W + $clog2(2 * NTAPS);

   // Coefficients and histories.
   logic signed [COEF_W-1:0]   num_coef_ff [NTAPS_MAX];
   logic signed [COEF_W-1:0]   den_coef_ff [NTAPS_MAX];
   logic signed [SAMPLE_W-1:0] xh_ff [NTAPS];
   logic signed [SAMPLE_W-1:0] yh_ff [NTAPS];

   // Sequencer.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] tap_cnt_ff;
   logic             tap_last;
   logic             req_accept;
   logic             mac_en;
   logic             div_start;
   logic             finish_go;

   // Multiply-accumulate datapath.
   logic [COEF_IDX_W-1:0]    coef_idx;
   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // Division and result formation.
   logic signed [COEF_W-1:0] den0;
   logic [ACC_W-1:0]         acc_mag;
   logic [COEF_W-1:0]        den_mag;
   logic [QUOT_W-1:0]        quotient;
   div_status_type           div_status;
   logic                     q_neg;
   logic                     fault;
   logic                     sat;
   logic signed [SAMPLE_W-1:0] y_result;

   // Output register.
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_y_sample_ff;
   logic                       rsp_saturated_ff;
   logic                       rsp_divide_fault_ff;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MAC;
         ST_MAC:    if (tap_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_status.done) state_in = ST_FINISH;
         ST_FINISH: if (finish_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      mac_en    = 1'b0;
      div_start = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_MAC:    mac_en = 1'b1;
         ST_LOAD:   div_start = 1'b1;
         ST_FINISH: finish_go = ~rsp_valid_ff | ~rsp_stall;
         default: begin
         end
      endcase
   end

   assign req_accept = req_valid & ~req_stall;
   assign tap_last   = (tap_cnt_ff == IDX_W'(NTAPS - 1));

   // State register and tap counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            tap_cnt_ff <= '0;
         end else if (mac_en && !tap_last) begin
            tap_cnt_ff <= tap_cnt_ff + 1'b1;
         end
      end
   end

   // Coefficient registers written through the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_coef_ff[0] <= COEF_UNITY;
         den_coef_ff[0] <= COEF_UNITY;
         for (int i = 1; i < NTAPS_MAX; i++) begin
            num_coef_ff[i] <= COEF_ZERO;
            den_coef_ff[i] <= COEF_ZERO;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_NUM_COEF_0: num_coef_ff[0] <= csr_wr_data;
            REG_NUM_COEF_1: num_coef_ff[1] <= csr_wr_data;
            REG_NUM_COEF_2: num_coef_ff[2] <= csr_wr_data;
            REG_NUM_COEF_3: num_coef_ff[3] <= csr_wr_data;
            REG_DEN_COEF_0: den_coef_ff[0] <= csr_wr_data;
            REG_DEN_COEF_1: den_coef_ff[1] <= csr_wr_data;
            REG_DEN_COEF_2: den_coef_ff[2] <= csr_wr_data;
            REG_DEN_COEF_3: den_coef_ff[3] <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Histories shift on each request; the newest output lands when it is known.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAPS; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (req_accept) begin
         for (int i = 1; i < NTAPS; i++) begin
            xh_ff[i] <= xh_ff[i-1];
            yh_ff[i] <= yh_ff[i-1];
         end
         xh_ff[0] <= req_x_sample;
         yh_ff[0] <= '0;
      end else if (finish_go) begin
         yh_ff[0] <= y_result;
      end
   end

   // One tap per cycle: both products are registered before accumulation.
   // The output history holds zero at the newest place, so tap zero adds nothing.
   assign coef_idx  = COEF_IDX_W'(tap_cnt_ff);
   assign prod_x_in = xh_ff[tap_cnt_ff] * num_coef_ff[coef_idx];
   assign prod_y_in = yh_ff[tap_cnt_ff] * den_coef_ff[coef_idx];
   assign acc_in    = acc_ff + ACC_W'(prod_x_ff) - ACC_W'(prod_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= mac_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      if (req_accept) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Magnitudes for the divider; the sign is applied afterwards.
   assign den0    = den_coef_ff[0];
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign den_mag = den0[COEF_W-1] ? COEF_W'(-den0) : COEF_W'(den0);

   iirdf1_div #(
      .DIVIDEND_W (ACC_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (acc_mag),
      .divisor   (den_mag),
      .quotient  (quotient),
      .status    (div_status)
   );

   // Sign, clipping and the zero-divisor case.
   always_comb begin
      q_neg = acc_ff[ACC_W-1] ^ den0[COEF_W-1];
      fault = (den0 == COEF_ZERO);
      if (q_neg) begin
         sat = div_status.overflow | (quotient > NEG_LIMIT_MAG);
      end else begin
         sat = div_status.overflow | quotient[QUOT_W-1];
      end
      if (fault) begin
         sat      = 1'b0;
         y_result = '0;
      end else if (sat) begin
         y_result = q_neg ? Y_MIN : Y_MAX;
      end else begin
         y_result = q_neg ? SAMPLE_W'(-quotient) : SAMPLE_W'(quotient);
      end
   end

   // Output register: loaded on finish, cleared when the response is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_y_sample_ff     <= y_result;
         rsp_saturated_ff    <= sat;
         rsp_divide_fault_ff <= fault;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_y_sample     = rsp_y_sample_ff;
   assign rsp_saturated    = rsp_saturated_ff;
   assign rsp_divide_fault = rsp_divide_fault_ff;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the direct form I IIR filter: predicts and compares outputs.
`timescale 1ns / 1ps

module testbench;
   import iirdf1_pkg::*;

   // One output sample of the filter with its flags.
   typedef struct {
      logic signed [SAMPLE_W-1:0] y_sample;
      logic                       saturated;
      logic                       divide_fault;
   } filter_out_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_x_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_y_sample;
   logic                       rsp_saturated;
   logic                       rsp_divide_fault;
   logic                       csr_wr_en = 1'b0;
   logic [REG_IDX_W-1:0]       csr_index = REG_NUM_COEF_0;
   logic [COEF_W-1:0]          csr_wr_data = '0;

   // Samples waiting to be sent and outputs still owed by the filter.
   logic signed [SAMPLE_W-1:0] sample_backlog[$];
   filter_out_type             expected_outputs[$];
   filter_out_type             oldest;
   logic                       req_taken = 1'b0;
   int                         req_idle_pct = 0;
   int                         rsp_stall_pct = 0;
   int                         mismatch_count = 0;

   // Own copy of the coefficients and of both histories.
   logic signed [COEF_W-1:0]   num_taps[NTAPS_DEFAULT] =
      '{COEF_UNITY, COEF_ZERO, COEF_ZERO, COEF_ZERO};
   logic signed [COEF_W-1:0]   den_taps[NTAPS_DEFAULT] =
      '{COEF_UNITY, COEF_ZERO, COEF_ZERO, COEF_ZERO};
   logic signed [SAMPLE_W-1:0] past_x[NTAPS_DEFAULT] = '{default: '0};
   logic signed [SAMPLE_W-1:0] past_y[NTAPS_DEFAULT] = '{default: '0};

   iir_direct_form_one dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_sample     (req_x_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_y_sample     (rsp_y_sample),
      .rsp_saturated    (rsp_saturated),
      .rsp_divide_fault (rsp_divide_fault),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shifts a new sample into the histories and works out the filter output.
   function automatic filter_out_type filter_step(logic signed [SAMPLE_W-1:0] x);
      longint         acc;
      longint         quotient;
      filter_out_type r;
      for (int i = NTAPS_DEFAULT - 1; i >= 1; i--) begin
         past_x[i] = past_x[i-1];
         past_y[i] = past_y[i-1];
      end
      past_x[0] = x;
      past_y[0] = '0;
      acc = 0;
      for (int i = 0; i < NTAPS_DEFAULT; i++) begin
         acc += longint'(past_x[i]) * longint'(num_taps[i]);
         if (i >= 1)
            acc -= longint'(past_y[i]) * longint'(den_taps[i]);
      end
      r.saturated    = 1'b0;
      r.divide_fault = 1'b0;
      if (den_taps[0] == 0) begin
         // A zero divisor forces the output to zero and raises the fault.
         r.divide_fault = 1'b1;
         r.y_sample     = '0;
      end else begin
         quotient = acc / longint'(den_taps[0]);
         if (quotient > longint'(Y_MAX)) begin
            quotient    = longint'(Y_MAX);
            r.saturated = 1'b1;
         end else if (quotient < longint'(Y_MIN)) begin
            quotient    = longint'(Y_MIN);
            r.saturated = 1'b1;
         end
         r.y_sample = SAMPLE_W'(quotient);
      end
      past_y[0] = r.y_sample;
      return r;
   endfunction

   // Request driver: a new sample is offered only once the previous one has gone.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_valid    <= 1'b1;
            req_x_sample <= sample_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Monitor: checks each response against the oldest prediction, then predicts new requests.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("response with no request outstanding: y_sample %0d", rsp_y_sample);
               mismatch_count++;
            end else begin
               oldest = expected_outputs.pop_front();
               if (rsp_y_sample !== oldest.y_sample) begin
                  $error("y_sample: expected %0d, got %0d", oldest.y_sample, rsp_y_sample);
                  mismatch_count++;
               end
               if (rsp_saturated !== oldest.saturated) begin
                  $error("saturated: expected %0b, got %0b", oldest.saturated, rsp_saturated);
                  mismatch_count++;
               end
               if (rsp_divide_fault !== oldest.divide_fault) begin
                  $error("divide_fault: expected %0b, got %0b",
                         oldest.divide_fault, rsp_divide_fault);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_outputs.push_back(filter_step(req_x_sample));
      end
   end

   // Writes one coefficient register and mirrors it in the predictor.
   task automatic write_coef(logic [REG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         REG_NUM_COEF_0: num_taps[0] = value;
         REG_NUM_COEF_1: num_taps[1] = value;
         REG_NUM_COEF_2: num_taps[2] = value;
         REG_NUM_COEF_3: num_taps[3] = value;
         REG_DEN_COEF_0: den_taps[0] = value;
         REG_DEN_COEF_1: den_taps[1] = value;
         REG_DEN_COEF_2: den_taps[2] = value;
         REG_DEN_COEF_3: den_taps[3] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_coefs(logic signed [COEF_W-1:0] n0, n1, n2, n3, d0, d1, d2, d3);
      write_coef(REG_NUM_COEF_0, n0);
      write_coef(REG_NUM_COEF_1, n1);
      write_coef(REG_NUM_COEF_2, n2);
      write_coef(REG_NUM_COEF_3, n3);
      write_coef(REG_DEN_COEF_0, d0);
      write_coef(REG_DEN_COEF_1, d1);
      write_coef(REG_DEN_COEF_2, d2);
      write_coef(REG_DEN_COEF_3, d3);
      @(posedge clock);
   endtask

   // Waits until every request has been sent and answered, then lets the core go quiet.
   task automatic settle();
      while (sample_backlog.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (NTAPS_DEFAULT + 21) @(posedge clock);
   endtask

   // A signed value spread evenly over [-span, span - 1].
   function automatic logic signed [COEF_W-1:0] rand_coef(int span);
      return COEF_W'(int'($urandom_range(0, 2 * span - 1)) - span);
   endfunction

   // Mostly full-range samples, some small ones and some at the rails.
   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         return SAMPLE_W'($urandom_range(0, 65535));
      else if (pick < 8)
         return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      else
         return pick[0] ? Y_MAX : Y_MIN;
   endfunction

   // Stimulus: directed cases first, then random phases under changing coefficients.
   initial begin
      int                       mode;
      logic signed [COEF_W-1:0] d0;
      req_idle_pct  = 29;
      rsp_stall_pct = 66;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients pass the sample straight through.
      sample_backlog.push_back(Y_MAX);  sample_backlog.push_back(Y_MIN);
      sample_backlog.push_back(16'sd0); sample_backlog.push_back(16'sd1);
      sample_backlog.push_back(-16'sd1);
      sample_backlog.push_back(16'sh5555); sample_backlog.push_back(16'shAAAA);
      settle();

      // Zero leading coefficient: fault flag, zero output, histories still move.
      load_coefs(COEF_UNITY, COEF_UNITY, COEF_ZERO, COEF_ZERO,
                 COEF_ZERO, COEF_UNITY, COEF_ZERO, COEF_ZERO);
      sample_backlog.push_back(16'sd1000); sample_backlog.push_back(-16'sd1000);
      settle();

      // Huge gain over a tiny divisor clips both ways.
      load_coefs(16'sd32767, 16'sd32767, COEF_ZERO, COEF_ZERO,
                 16'sd1, COEF_ZERO, COEF_ZERO, COEF_ZERO);
      sample_backlog.push_back(Y_MAX); sample_backlog.push_back(Y_MIN);
      sample_backlog.push_back(Y_MIN); sample_backlog.push_back(16'sd0);
      settle();

      // Divide by three with feedback: quotients truncate towards zero.
      load_coefs(COEF_UNITY, COEF_ZERO, COEF_ZERO, COEF_ZERO,
                 16'sd12288, -16'sd2048, COEF_ZERO, COEF_ZERO);
      sample_backlog.push_back(-16'sd7); sample_backlog.push_back(16'sd7);
      sample_backlog.push_back(Y_MIN);   sample_backlog.push_back(16'sd100);
      settle();

      // Negative divisor with the deeper taps in use.
      load_coefs(COEF_UNITY, COEF_ZERO, COEF_ZERO, -16'sd8192,
                 -16'sd4096, COEF_ZERO, 16'sd1024, -16'sd1024);
      sample_backlog.push_back(16'sd12345); sample_backlog.push_back(-16'sd5);
      sample_backlog.push_back(Y_MAX);      sample_backlog.push_back(16'sd3);
      settle();

      for (int phase = 0; phase < 10; phase++) begin
         // Sender and receiver swap their idle rates, then both run flat out.
         if (phase == 4) begin
            req_idle_pct  = 66;
            rsp_stall_pct = 29;
         end else if (phase == 7) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         if (phase == 0) begin
            load_coefs(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                       16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
         end else if (phase == 1) begin
            load_coefs(Y_MIN, Y_MIN, Y_MIN, Y_MIN, Y_MIN, Y_MIN, Y_MIN, Y_MIN);
         end else begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
               // Anything goes.
               load_coefs(rand_coef(32768), rand_coef(32768), rand_coef(32768),
                          rand_coef(32768), rand_coef(32768), rand_coef(32768),
                          rand_coef(32768), rand_coef(32768));
            end else begin
               // Stable-ish filters, so that outputs are not all at the rails.
               if (mode == 2)
                  d0 = COEF_ZERO;
               else if (mode < 6)
                  d0 = COEF_UNITY;
               else
                  d0 = COEF_W'(int'($urandom_range(2048, 16384)) * (mode[0] ? 1 : -1));
               load_coefs(rand_coef(8192), rand_coef(8192), rand_coef(8192),
                          rand_coef(8192), d0, rand_coef(2048), rand_coef(2048),
                          rand_coef(2048));
            end
         end
         repeat (98) sample_backlog.push_back(rand_sample());
         settle();
      end

      if (mismatch_count == 0)
         $display("PASS iir_direct_form_one");
      else
         $display("FAIL iir_direct_form_one");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("FAIL iir_direct_form_one");
      $finish;
   end

endmodule

>>> filelist.f
design/iirdf1_pkg.sv
design/iirdf1_div.sv
design/iir_direct_form_one.sv
verif/testbench.sv
